@@ rtl/pba_pkg.sv @@
// Shared types and constants of the page block allocator.
package pba_pkg;

  localparam int unsigned SizeW    = 26;
  localparam int unsigned PageW    = 10;
  localparam int unsigned ShiftW   = 5;
  localparam int unsigned HdrW     = 6;
  localparam int unsigned ArenaW   = 11;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 11;

  localparam logic [CfgIdxW-1:0] CfgPageShift = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgHeader    = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgArena     = 2'd2;

  localparam logic [ShiftW-1:0] PageShiftRst = 5'd12;
  localparam logic [HdrW-1:0]   HeaderRst    = 6'd16;
  localparam logic [ArenaW-1:0] ArenaRst     = 11'd1024;
  localparam logic [ShiftW-1:0] ShiftMin     = 5'd6;
  localparam logic [ShiftW-1:0] ShiftMax     = 5'd16;
  localparam logic [HdrW-1:0]   HdrMin       = 6'd8;
  localparam logic [ArenaW-1:0] ArenaMin     = 11'd2;

  typedef enum logic [1:0] {
    KIND_ALLOC,
    KIND_FREE,
    KIND_REALLOC,
    KIND_CLEAR
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK,
    ST_NO_SPACE,
    ST_ALREADY_FREE,
    ST_OUTSIDE
  } status_e;

  typedef enum logic [4:0] {
    S_CLR,
    S_IDLE,
    S_PRE,
    S_CHK,
    S_FR_RD,
    S_FR_NX,
    S_FR_W,
    S_RA_RD,
    S_RA_NX,
    S_RA_W,
    S_RA_DEC,
    S_RA_SPL,
    S_RA_OK,
    S_A_INIT,
    S_A_HINT,
    S_F_RD,
    S_F_CHK,
    S_F_NX,
    S_F_AB,
    S_FD1,
    S_FD2,
    S_FD3,
    S_A_OK,
    S_OF_A,
    S_OF_B,
    S_FIN
  } pba_state_e;

endpackage

@@ rtl/page_block_allocator_core.sv @@
// Page block allocator: block table memory, size-class hints and request sequencer.
//
// Usage. Requests enter on in_valid_i/in_ready_o with kind_i, block_page_i and
// size_bytes_i; one result per request leaves on out_valid_o/out_ready_i.
// Configuration writes (cfg_valid_i/cfg_ready_o, cfg_index_i, cfg_data_i) are
// always accepted; issue them only while no request is in flight. Each write to
// a listed register clears the arena. The block handles one request at a time:
// in_ready_o is high only when the sequencer is idle.
// The block table memory has a synchronous read, so a request costs more the more
// blocks it probes, walks or merges; a reallocate may run a grow, an allocate and
// a free phase in turn. A clear request sweeps the whole table before its result.
// Reset. After reset the table is swept (in_ready_o low), leaving one free block
// that spans the arena; configuration writes restart that sweep. Stall. A finished
// result moves into the output register once that register is free, and the next
// request is then taken; a result still waiting there holds the following result
// in the sequencer until it is handed over.
module page_block_allocator_core
  import pba_pkg::*;
#(
  parameter int unsigned NUM_PAGES    = 1024,
  parameter int unsigned HINT_CLASSES = 10
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          kind_i,
  input  logic [PageW-1:0]    block_page_i,
  input  logic [SizeW-1:0]    size_bytes_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [1:0]          status_o,
  output logic [PageW-1:0]    result_page_o,
  output logic [SizeW-1:0]    real_bytes_o,
  output logic                moved_o,
  output logic [SizeW-1:0]    copy_bytes_o
);

  localparam int unsigned PW = $clog2(NUM_PAGES);
  localparam int unsigned LW = $clog2(NUM_PAGES + 1);
  localparam int unsigned CW = (HINT_CLASSES > 1) ? $clog2(HINT_CLASSES) : 1;
  localparam int unsigned HW = $clog2(HINT_CLASSES + 1);

  typedef struct packed {
    logic          free;
    logic [LW-1:0] len;
  } blk_t;

  function automatic logic [CW-1:0] hint_class(input logic [LW-1:0] n);
    logic [LW-1:0] m;
    int unsigned   c;
    m = n - LW'(1);
    c = 0;
    if (n > LW'(1)) begin
      for (int i = 0; i < LW; i++) begin
        if (m[i]) c = i + 1;
      end
    end
    if (c >= HINT_CLASSES) c = HINT_CLASSES - 1;
    return CW'(c);
  endfunction

  function automatic logic [SizeW-1:0] real_of(input logic [LW-1:0] p,
                                               input logic [ShiftW-1:0] sh,
                                               input logic [HdrW-1:0] hdr);
    logic [47:0] t;
    t = (48'(p) << sh) - 48'(hdr);
    return t[SizeW-1:0];
  endfunction

  // configuration
  logic [ShiftW-1:0] shift_q, shift_d;
  logic [HdrW-1:0]   hdr_q, hdr_d;
  logic [ArenaW-1:0] arena_q, arena_d;
  logic [ShiftW-1:0] sh_eff;
  logic [HdrW-1:0]   hdr_eff;
  logic [LW-1:0]     a_eff;
  logic              cfg_clr;

  // sequencer
  pba_state_e state_q, state_d, ret_q, ret_d;
  logic [PW-1:0] ctr_q, ctr_d;
  kind_e         kind_q, kind_d;
  logic [LW-1:0] bp_q, bp_d, need_q, need_d, cur_q, cur_d, len_q, len_d;
  logic [LW-1:0] nxlen_q, nxlen_d, got_q, got_d, glen_q, glen_d, blen_q, blen_d;
  logic [LW-1:0] of_page_q, of_page_d, of_len_q, of_len_d;
  logic [CW-1:0] of_c_q, of_c_d;
  logic [HW-1:0] hc_q, hc_d;
  logic          need_big_q, need_big_d, bp_oor_q, bp_oor_d, one_q, one_d;
  logic          grow_q, grow_d;
  logic          clr_resp_q, clr_resp_d;
  logic [SizeW-1:0] size_q, size_d, old_q, old_d;

  status_e          res_status_q, res_status_d;
  logic [LW-1:0]    res_page_q, res_page_d;
  logic [SizeW-1:0] res_real_q, res_real_d, res_copy_q, res_copy_d;
  logic             res_moved_q, res_moved_d;

  logic             out_valid_q, out_valid_d;
  status_e          out_status_q, out_status_d;
  logic [PageW-1:0] out_page_q, out_page_d;
  logic [SizeW-1:0] out_real_q, out_real_d, out_copy_q, out_copy_d;
  logic             out_moved_q, out_moved_d;

  // need computation on the incoming request
  logic [27:0] need_sum, need_full;

  // block table and recorded sizes
  blk_t             blk_mem [NUM_PAGES];
  blk_t             blk_rd_q, blk_wdata;
  logic             blk_re, blk_we, rs_re, rs_we;
  logic [PW-1:0]    blk_raddr, blk_waddr, rs_waddr;
  logic [SizeW-1:0] rs_mem [NUM_PAGES];
  logic [SizeW-1:0] rs_rd_q, rs_wdata;

  // hints
  logic [PW-1:0]       hint_start_q [HINT_CLASSES];
  logic [HINT_CLASSES-1:0] hint_valid_q;
  logic [CW-1:0]       hint_rc, hint_wc;
  logic                hint_rd_valid;
  logic [PW-1:0]       hint_rd_start;
  logic                hint_clear, hint_inv, hint_set;
  logic [LW-1:0]       hint_set_page;

  // derived values
  logic [LW-1:0] rd_len, nx_cur, nx_bp, nx_rd, split_cur, split_bp;
  logic          rd_free, ra_grow, find_fail, out_free;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == S_IDLE);
  assign cfg_clr     = cfg_valid_i && (cfg_index_i == CfgPageShift ||
                       cfg_index_i == CfgHeader || cfg_index_i == CfgArena);

  assign sh_eff  = (shift_q < ShiftMin) ? ShiftMin : ((shift_q > ShiftMax) ? ShiftMax : shift_q);
  assign hdr_eff = (hdr_q < HdrMin) ? HdrMin : hdr_q;
  always_comb begin
    if (arena_q < ArenaMin) begin
      a_eff = LW'(ArenaMin);
    end else if (32'(arena_q) > 32'(NUM_PAGES)) begin
      a_eff = LW'(NUM_PAGES);
    end else begin
      a_eff = LW'(arena_q);
    end
  end

  assign need_sum  = 28'(size_bytes_i) + 28'(hdr_eff) + ((28'd1 << sh_eff) - 28'd1);
  assign need_full = need_sum >> sh_eff;

  assign rd_len    = blk_rd_q.len;
  assign rd_free   = blk_rd_q.free;
  assign nx_cur    = cur_q + len_q;
  assign nx_bp     = bp_q + blen_q;
  assign nx_rd     = cur_q + rd_len;
  assign split_cur = cur_q + need_q;
  assign split_bp  = bp_q + need_q;
  assign ra_grow   = need_big_q || (need_q > blen_q);
  assign out_free  = !out_valid_q || out_ready_i;

  assign hint_rd_valid = hint_valid_q[hint_rc];
  assign hint_rd_start = hint_start_q[hint_rc];

  // hint read index per state
  always_comb begin
    case (state_q)
      S_F_NX, S_FR_NX, S_RA_NX: hint_rc = hint_class(rd_len);
      S_F_AB, S_FD1:            hint_rc = hint_class(len_q);
      S_OF_A:                   hint_rc = hint_class(of_len_q);
      S_A_HINT:                 hint_rc = hc_q[CW-1:0];
      default:                  hint_rc = '0;
    endcase
  end

  always_comb begin
    case (state_q)
      S_F_RD:  find_fail = (cur_q >= a_eff);
      S_F_CHK: find_fail = (rd_len == '0) || (!rd_free && one_q) ||
                           (rd_free && (rd_len < need_q) && (nx_rd >= a_eff));
      S_F_NX:  find_fail = !rd_free && one_q;
      default: find_fail = 1'b0;
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLR:    if (ctr_q == PW'(NUM_PAGES - 1)) state_d = clr_resp_q ? S_FIN : S_IDLE;
      S_IDLE: begin
        if (in_valid_i) begin
          unique case (kind_e'(kind_i))
            KIND_ALLOC:              state_d = S_A_INIT;
            KIND_FREE, KIND_REALLOC: state_d = S_PRE;
            KIND_CLEAR:              state_d = S_CLR;
            default:                 state_d = S_IDLE;
          endcase
        end
      end
      S_PRE:    state_d = bp_oor_q ? S_FIN : S_CHK;
      S_CHK: begin
        if (rd_len == '0 || rd_free) state_d = S_FIN;
        else state_d = (kind_q == KIND_FREE) ? S_FR_RD : S_RA_RD;
      end
      S_FR_RD:  state_d = (nx_bp < a_eff) ? S_FR_NX : S_FR_W;
      S_FR_NX:  state_d = S_FR_W;
      S_FR_W:   state_d = S_OF_A;
      // once growing, absorb every following free block
      S_RA_RD:  state_d = (grow_q && nx_bp < a_eff) ? S_RA_NX : S_RA_DEC;
      S_RA_NX:  state_d = rd_free ? S_RA_W : S_RA_DEC;
      S_RA_W:   state_d = S_RA_RD;
      S_RA_DEC: begin
        if (ra_grow) state_d = S_A_INIT;
        else state_d = (blen_q > need_q) ? S_RA_SPL : S_RA_OK;
      end
      S_RA_SPL: state_d = S_OF_A;
      S_RA_OK:  state_d = S_FIN;
      S_A_INIT: state_d = need_big_q ? S_FIN : S_A_HINT;
      S_A_HINT: begin
        if (hc_q == HW'(HINT_CLASSES) || hint_rd_valid) state_d = S_F_RD;
      end
      S_F_RD:   state_d = S_F_CHK;
      S_F_CHK: begin
        if (!rd_free) state_d = S_F_RD;
        else if (rd_len >= need_q) state_d = S_FD1;
        else state_d = S_F_NX;
      end
      S_F_NX:   state_d = rd_free ? S_F_AB : S_F_RD;
      S_F_AB:   state_d = S_OF_A;
      S_FD1: begin
        if (len_q > need_q) state_d = S_FD2;
        else state_d = (nx_cur < a_eff) ? S_FD3 : S_A_OK;
      end
      S_FD2:    state_d = S_OF_A;
      S_FD3:    state_d = rd_free ? S_OF_A : S_A_OK;
      S_A_OK:   state_d = (kind_q == KIND_ALLOC) ? S_FIN : S_FR_RD;
      S_OF_A: begin
        if (of_page_q >= a_eff || !hint_rd_valid) state_d = ret_q;
        else state_d = S_OF_B;
      end
      S_OF_B:   state_d = ret_q;
      S_FIN:    if (out_free) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
    if (find_fail) state_d = one_q ? S_A_HINT : S_FIN;
    if (cfg_clr) state_d = S_CLR;
  end

  // datapath, memory and hint controls
  always_comb begin
    shift_d = shift_q; hdr_d = hdr_q; arena_d = arena_q;
    ctr_d = ctr_q; kind_d = kind_q; bp_d = bp_q; need_d = need_q; cur_d = cur_q;
    len_d = len_q; nxlen_d = nxlen_q; got_d = got_q; glen_d = glen_q; blen_d = blen_q;
    of_page_d = of_page_q; of_len_d = of_len_q; of_c_d = of_c_q; hc_d = hc_q;
    need_big_d = need_big_q; bp_oor_d = bp_oor_q; one_d = one_q; grow_d = grow_q;
    clr_resp_d = clr_resp_q; size_d = size_q; old_d = old_q; ret_d = ret_q;
    res_status_d = res_status_q; res_page_d = res_page_q; res_real_d = res_real_q;
    res_copy_d = res_copy_q; res_moved_d = res_moved_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_status_d = out_status_q; out_page_d = out_page_q; out_real_d = out_real_q;
    out_copy_d = out_copy_q; out_moved_d = out_moved_q;
    blk_re = 1'b0; blk_raddr = '0; blk_we = 1'b0; blk_waddr = '0; blk_wdata = '0;
    rs_re = 1'b0; rs_we = 1'b0; rs_waddr = '0; rs_wdata = '0;
    hint_clear = 1'b0; hint_inv = 1'b0; hint_set = 1'b0; hint_wc = '0; hint_set_page = '0;

    case (state_q)
      S_CLR: begin
        blk_we    = 1'b1;
        blk_waddr = ctr_q;
        if (ctr_q == '0) begin
          blk_wdata  = '{free: 1'b1, len: a_eff};
          hint_clear = 1'b1;
        end
        ctr_d = ctr_q + PW'(1);
        if (ctr_q == PW'(NUM_PAGES - 1)) clr_resp_d = 1'b0;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          kind_d       = kind_e'(kind_i);
          bp_d         = LW'(block_page_i);
          bp_oor_d     = (32'(block_page_i) >= 32'(a_eff));
          size_d       = size_bytes_i;
          need_d       = LW'(need_full);
          need_big_d   = (need_full > 28'(a_eff));
          res_status_d = ST_OK;
          res_page_d   = '0;
          res_real_d   = '0;
          res_copy_d   = '0;
          res_moved_d  = 1'b0;
          if (kind_e'(kind_i) == KIND_CLEAR) begin
            ctr_d      = '0;
            clr_resp_d = 1'b1;
          end
        end
      end
      S_PRE: begin
        if (bp_oor_q) begin
          res_status_d = ST_OUTSIDE;
        end else begin
          blk_re    = 1'b1;
          rs_re     = 1'b1;
          blk_raddr = bp_q[PW-1:0];
        end
      end
      S_CHK: begin
        if (rd_len == '0) res_status_d = ST_OUTSIDE;
        else if (rd_free) res_status_d = ST_ALREADY_FREE;
        blen_d = rd_len;
        old_d  = rs_rd_q;
        grow_d = need_big_q || (need_q > rd_len);
      end
      S_FR_RD: begin
        blk_re    = 1'b1;
        blk_raddr = nx_bp[PW-1:0];
      end
      S_FR_NX: begin
        if (rd_free) begin
          hint_inv  = hint_rd_valid && (LW'(hint_rd_start) == nx_bp);
          hint_wc   = hint_rc;
          blk_we    = 1'b1;
          blk_waddr = nx_bp[PW-1:0];
          blen_d    = blen_q + rd_len;
        end
      end
      S_FR_W: begin
        blk_we    = 1'b1;
        blk_waddr = bp_q[PW-1:0];
        blk_wdata = '{free: 1'b1, len: blen_q};
        of_page_d = bp_q;
        of_len_d  = blen_q;
        ret_d     = S_FIN;
        if (kind_q == KIND_FREE) res_page_d = bp_q;
      end
      S_RA_RD: begin
        blk_re    = 1'b1;
        blk_raddr = nx_bp[PW-1:0];
      end
      S_RA_NX: begin
        if (rd_free) begin
          hint_inv  = hint_rd_valid && (LW'(hint_rd_start) == nx_bp);
          hint_wc   = hint_rc;
          blk_we    = 1'b1;
          blk_waddr = nx_bp[PW-1:0];
          nxlen_d   = rd_len;
        end
      end
      S_RA_W: begin
        blen_d    = blen_q + nxlen_q;
        blk_we    = 1'b1;
        blk_waddr = bp_q[PW-1:0];
        blk_wdata = '{free: 1'b0, len: blen_q + nxlen_q};
      end
      S_RA_DEC: begin
        if (!ra_grow) begin
          if (blen_q > need_q) begin
            blk_we    = 1'b1;
            blk_waddr = bp_q[PW-1:0];
            blk_wdata = '{free: 1'b0, len: need_q};
            nxlen_d   = blen_q - need_q;
            glen_d    = need_q;
          end else begin
            glen_d = blen_q;
          end
        end
      end
      S_RA_SPL: begin
        blk_we    = 1'b1;
        blk_waddr = split_bp[PW-1:0];
        blk_wdata = '{free: 1'b1, len: nxlen_q};
        of_page_d = split_bp;
        of_len_d  = nxlen_q;
        ret_d     = S_RA_OK;
      end
      S_RA_OK: begin
        rs_we      = 1'b1;
        rs_waddr   = bp_q[PW-1:0];
        rs_wdata   = real_of(glen_q, sh_eff, hdr_eff);
        res_page_d = bp_q;
        res_real_d = real_of(glen_q, sh_eff, hdr_eff);
      end
      S_A_INIT: begin
        if (need_big_q) res_status_d = ST_NO_SPACE;
        else hc_d = HW'(hint_class(need_q));
      end
      S_A_HINT: begin
        if (hc_q == HW'(HINT_CLASSES)) begin
          one_d = 1'b0;
          cur_d = '0;
        end else if (hint_rd_valid) begin
          one_d = 1'b1;
          cur_d = LW'(hint_rd_start);
        end else begin
          hc_d = hc_q + HW'(1);
        end
      end
      S_F_RD: begin
        blk_re    = 1'b1;
        blk_raddr = cur_q[PW-1:0];
      end
      S_F_CHK: begin
        len_d = rd_len;
        if (!rd_free) begin
          cur_d = cur_q + rd_len;
        end else if (rd_len < need_q) begin
          blk_re    = 1'b1;
          blk_raddr = nx_rd[PW-1:0];
        end
      end
      S_F_NX: begin
        if (!rd_free) begin
          cur_d = nx_cur;
        end else begin
          hint_inv  = hint_rd_valid && (LW'(hint_rd_start) == nx_cur);
          hint_wc   = hint_rc;
          blk_we    = 1'b1;
          blk_waddr = nx_cur[PW-1:0];
          nxlen_d   = rd_len;
        end
      end
      S_F_AB: begin
        hint_inv  = hint_rd_valid && (LW'(hint_rd_start) == cur_q);
        hint_wc   = hint_rc;
        blk_we    = 1'b1;
        blk_waddr = cur_q[PW-1:0];
        blk_wdata = '{free: 1'b1, len: len_q + nxlen_q};
        of_page_d = cur_q;
        of_len_d  = len_q + nxlen_q;
        ret_d     = S_F_RD;
      end
      S_FD1: begin
        hint_inv  = hint_rd_valid && (LW'(hint_rd_start) == cur_q);
        hint_wc   = hint_rc;
        got_d     = cur_q;
        blk_we    = 1'b1;
        blk_waddr = cur_q[PW-1:0];
        if (len_q > need_q) begin
          blk_wdata = '{free: 1'b0, len: need_q};
          glen_d    = need_q;
          nxlen_d   = len_q - need_q;
        end else begin
          blk_wdata = '{free: 1'b0, len: len_q};
          glen_d    = len_q;
          blk_re    = 1'b1;
          blk_raddr = nx_cur[PW-1:0];
        end
      end
      S_FD2: begin
        blk_we    = 1'b1;
        blk_waddr = split_cur[PW-1:0];
        blk_wdata = '{free: 1'b1, len: nxlen_q};
        of_page_d = split_cur;
        of_len_d  = nxlen_q;
        ret_d     = S_A_OK;
      end
      S_FD3: begin
        of_page_d = nx_cur;
        of_len_d  = rd_len;
        ret_d     = S_A_OK;
      end
      S_A_OK: begin
        rs_we      = 1'b1;
        rs_waddr   = got_q[PW-1:0];
        rs_wdata   = real_of(glen_q, sh_eff, hdr_eff);
        res_page_d = got_q;
        res_real_d = real_of(glen_q, sh_eff, hdr_eff);
        if (kind_q == KIND_REALLOC) begin
          res_moved_d = 1'b1;
          res_copy_d  = (size_q < old_q) ? size_q : old_q;
        end
      end
      S_OF_A: begin
        of_c_d = hint_rc;
        if (of_page_q < a_eff) begin
          if (!hint_rd_valid) begin
            hint_set      = 1'b1;
            hint_wc       = hint_rc;
            hint_set_page = of_page_q;
          end else begin
            blk_re    = 1'b1;
            blk_raddr = hint_rd_start;
          end
        end
      end
      S_OF_B: begin
        if (of_len_q > rd_len) begin
          hint_set      = 1'b1;
          hint_wc       = of_c_q;
          hint_set_page = of_page_q;
        end
      end
      S_FIN: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_page_d   = PageW'(res_page_q);
          out_real_d   = res_real_q;
          out_copy_d   = res_copy_q;
          out_moved_d  = res_moved_q;
        end
      end
      default: begin
      end
    endcase

    // drop to the next hint class, or give up the walk
    if (find_fail) begin
      if (one_q) hc_d = hc_q + HW'(1);
      else res_status_d = ST_NO_SPACE;
    end

    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgPageShift: shift_d = cfg_data_i[ShiftW-1:0];
        CfgHeader:    hdr_d   = cfg_data_i[HdrW-1:0];
        CfgArena:     arena_d = cfg_data_i[ArenaW-1:0];
        default: begin
        end
      endcase
      if (cfg_clr) begin
        ctr_d      = '0;
        clr_resp_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLR;
      ret_q        <= S_FIN;
      ctr_q        <= '0;
      shift_q      <= PageShiftRst;
      hdr_q        <= HeaderRst;
      arena_q      <= ArenaRst;
      clr_resp_q   <= 1'b0;
      kind_q       <= KIND_ALLOC;
      hc_q         <= '0;
      one_q        <= 1'b0;
      out_valid_q  <= 1'b0;
      res_status_q <= ST_OK;
      out_status_q <= ST_OK;
    end else begin
      state_q      <= state_d;
      ret_q        <= ret_d;
      ctr_q        <= ctr_d;
      shift_q      <= shift_d;
      hdr_q        <= hdr_d;
      arena_q      <= arena_d;
      clr_resp_q   <= clr_resp_d;
      kind_q       <= kind_d;
      hc_q         <= hc_d;
      one_q        <= one_d;
      out_valid_q  <= out_valid_d;
      res_status_q <= res_status_d;
      out_status_q <= out_status_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bp_q        <= bp_d;
    bp_oor_q    <= bp_oor_d;
    need_q      <= need_d;
    need_big_q  <= need_big_d;
    grow_q      <= grow_d;
    size_q      <= size_d;
    old_q       <= old_d;
    cur_q       <= cur_d;
    len_q       <= len_d;
    nxlen_q     <= nxlen_d;
    got_q       <= got_d;
    glen_q      <= glen_d;
    blen_q      <= blen_d;
    of_page_q   <= of_page_d;
    of_len_q    <= of_len_d;
    of_c_q      <= of_c_d;
    res_page_q  <= res_page_d;
    res_real_q  <= res_real_d;
    res_copy_q  <= res_copy_d;
    res_moved_q <= res_moved_d;
    out_page_q  <= out_page_d;
    out_real_q  <= out_real_d;
    out_copy_q  <= out_copy_d;
    out_moved_q <= out_moved_d;
  end

  // block table: write-first forwarding on a same-address read
  always_ff @(posedge clk_i) begin
    if (blk_we) blk_mem[blk_waddr] <= blk_wdata;
    if (blk_re) begin
      if (blk_we && blk_waddr == blk_raddr) blk_rd_q <= blk_wdata;
      else blk_rd_q <= blk_mem[blk_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rs_we) rs_mem[rs_waddr] <= rs_wdata;
    if (rs_re) rs_rd_q <= rs_mem[blk_raddr];
  end

  // size-class hints
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hint_valid_q <= '0;
      for (int i = 0; i < HINT_CLASSES; i++) hint_start_q[i] <= '0;
    end else if (hint_clear) begin
      hint_valid_q <= '0;
      for (int i = 0; i < HINT_CLASSES; i++) hint_start_q[i] <= '0;
      hint_valid_q[hint_class(a_eff)] <= 1'b1;
    end else if (hint_inv) begin
      hint_valid_q[hint_wc] <= 1'b0;
    end else if (hint_set) begin
      hint_valid_q[hint_wc] <= 1'b1;
      hint_start_q[hint_wc] <= hint_set_page[PW-1:0];
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign result_page_o = out_page_q;
  assign real_bytes_o  = out_real_q;
  assign moved_o       = out_moved_q;
  assign copy_bytes_o  = out_copy_q;

endmodule
